>>> rtl/nbma_pkg.sv
// ----------------------------------------------------------------------------
// nbma_pkg: shared constants and mod-q helpers
// Field widths, modulus, Barrett constants and register codes used by the
// base multiply and accumulate block.
// ----------------------------------------------------------------------------
package nbma_pkg;

    localparam int unsigned COEF_W        = 12;
    localparam int unsigned PAIR_W        = 7;
    localparam int unsigned COL_W         = 2;
    localparam int unsigned CFG_COLS_W    = 3;
    localparam int unsigned COEFFS_DEFAULT = 256;

    localparam int unsigned MODQ          = 3329;
    localparam logic [COEF_W-1:0] MODQ_C  = COEF_W'(MODQ);

    // Barrett reduction of sums below 2^(RED_X_W).
    localparam int unsigned RED_X_W       = 25;
    localparam int unsigned BARRETT_K     = 26;
    localparam int unsigned BARRETT_M     = (1 << BARRETT_K) / MODQ;
    localparam int unsigned BARRETT_M_W   = $clog2(BARRETT_M + 1);

    // Register map: index decoded from paddr[2].
    localparam logic IDX_COLUMNS_IN_ROW   = 1'b0;
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(3);
    localparam logic [CFG_COLS_W-1:0] COLS_MAX   = CFG_COLS_W'(4);

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [COEF_W-1:0] hi;
        logic [COEF_W-1:0] lo;
    } t_result;

    function automatic logic [COEF_W-1:0] reduce_once(input logic [COEF_W-1:0] x);
        logic [COEF_W-1:0] r;
        r = (x >= MODQ_C) ? x - MODQ_C : x;
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] neg_mod(input logic [COEF_W-1:0] x);
        logic [COEF_W-1:0] r;
        r = (x == '0) ? '0 : MODQ_C - x;
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] add_mod(input logic [COEF_W-1:0] a,
                                                   input logic [COEF_W-1:0] b);
        logic [COEF_W:0] s;
        logic [COEF_W:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = (s >= {1'b0, MODQ_C}) ? s - {1'b0, MODQ_C} : s;
        return r[COEF_W-1:0];
    endfunction

endpackage

>>> rtl/ntt_basemul_accumulate_mod_q_unit.sv
// ----------------------------------------------------------------------------
// ntt_basemul_accumulate_mod_q_unit: NTT-domain base multiply and accumulate
// Streams coefficient pairs of A, s and e and produces one row of A*s + e
// mod 3329, one pair at a time.
// ----------------------------------------------------------------------------
// Usage: each request on the s_axis channel carries an A pair, an s pair,
// an e pair, the group zeta and the pair index in tdata, and the column in
// tuser. Column zero starts a fresh sum for that pair, later columns add to
// it, and the column equal to columns_in_row - 1 returns (sum + e) mod q on
// the m_axis channel together with the pair index.
// columns_in_row is written over the APB port at byte address 0; the user
// must do so only while idle, not enforced by the block; reads return its value.
// The datapath is a nine-stage pipeline that takes one request per cycle
// while the output buffer is not full. A result passes through the input
// and product stages, two two-stage Barrett reductions in series around
// the even-sum stage, the accumulator update and the final error add, and
// then the output buffer before it appears on m_axis.
// The per-pair sums live in a memory of COEFFS/2 words, read one stage
// before the update with forwarding of the previous update.
// Reset clears all valid bits and the output buffer and sets
// columns_in_row to 3; the sum memory is not cleared.
// When the receiver stalls, a two-entry output buffer keeps accepting
// until it is full, then the whole pipeline holds with nothing lost.
// ----------------------------------------------------------------------------
module ntt_basemul_accumulate_mod_q_unit #(
    parameter int unsigned COEFFS = nbma_pkg::COEFFS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: a_lo, a_hi, s_lo, s_hi, err_lo, err_hi, twiddle, pair_index, zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    // tuser: column
    input  logic [1:0]  s_axis_tuser,
    // tdata: t_lo, t_hi, out_pair_index, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW         = nbma_pkg::COEF_W;
    localparam int unsigned PW         = nbma_pkg::PAIR_W;
    localparam int unsigned XW         = nbma_pkg::RED_X_W;
    localparam int unsigned PAIRS      = COEFFS / 2;
    localparam int unsigned SLOT_W     = $clog2(PAIRS);
    localparam int unsigned PAIR_CODES = 2 ** PW;
    localparam int unsigned PROD_W     = 2 * CW;

    // Configuration.
    logic [nbma_pkg::CFG_COLS_W-1:0] r_cols;
    logic [nbma_pkg::CFG_COLS_W-1:0] w_cols_eff;
    logic [nbma_pkg::COL_W-1:0]      w_last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= nbma_pkg::COLS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == nbma_pkg::IDX_COLUMNS_IN_ROW)) begin
            r_cols <= pwdata[nbma_pkg::CFG_COLS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == nbma_pkg::IDX_COLUMNS_IN_ROW) ? 32'(r_cols) : 32'd0;

    always_comb begin
        w_cols_eff = r_cols;
        if (r_cols == '0) begin
            w_cols_eff = nbma_pkg::CFG_COLS_W'(1);
        end else if (r_cols > nbma_pkg::COLS_MAX) begin
            w_cols_eff = nbma_pkg::COLS_MAX;
        end
        w_last_col = nbma_pkg::COL_W'(w_cols_eff - nbma_pkg::CFG_COLS_W'(1));
    end

    // Pipeline control.
    logic        w_en;
    logic [9:1]  r_vld;
    logic [1:0]  r_cnt;

    assign w_en          = (r_cnt != 2'd2);
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[8:1], s_axis_tvalid};
        end
    end

    // Pair index to memory slot.
    logic [SLOT_W-1:0] w_slot_lut [PAIR_CODES];

    for (genvar g = 0; g < PAIR_CODES; g++) begin : g_slot
        assign w_slot_lut[g] = SLOT_W'(g % PAIRS);
    end

    // Input fields.
    logic [CW-1:0] w_a_lo, w_a_hi, w_s_lo, w_s_hi, w_e_lo, w_e_hi, w_tw, w_z;
    logic [PW-1:0] w_pair;
    logic [nbma_pkg::COL_W-1:0] w_col;

    always_comb begin
        w_a_lo = nbma_pkg::reduce_once(s_axis_tdata[11:0]);
        w_a_hi = nbma_pkg::reduce_once(s_axis_tdata[23:12]);
        w_s_lo = nbma_pkg::reduce_once(s_axis_tdata[35:24]);
        w_s_hi = nbma_pkg::reduce_once(s_axis_tdata[47:36]);
        w_e_lo = nbma_pkg::reduce_once(s_axis_tdata[59:48]);
        w_e_hi = nbma_pkg::reduce_once(s_axis_tdata[71:60]);
        w_tw   = nbma_pkg::reduce_once(s_axis_tdata[83:72]);
        w_pair = s_axis_tdata[90:84];
        w_col  = s_axis_tuser;
        w_z    = w_pair[0] ? nbma_pkg::neg_mod(w_tw) : w_tw;
    end

    // Stage 1: reduced operands.
    logic [CW-1:0]     r1_a_lo, r1_a_hi, r1_s_lo, r1_s_hi, r1_e_lo, r1_e_hi, r1_z;
    logic [PW-1:0]     r1_pair;
    logic [SLOT_W-1:0] r1_slot;
    logic              r1_col0, r1_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a_lo <= w_a_lo;
            r1_a_hi <= w_a_hi;
            r1_s_lo <= w_s_lo;
            r1_s_hi <= w_s_hi;
            r1_e_lo <= w_e_lo;
            r1_e_hi <= w_e_hi;
            r1_z    <= w_z;
            r1_pair <= w_pair;
            r1_slot <= w_slot_lut[w_pair];
            r1_col0 <= (w_col == '0);
            r1_last <= (w_col == w_last_col);
        end
    end

    // Stage 2: partial products.
    logic [PROD_W-1:0] w_p_ll, w_p_hh, w_p_lh, w_p_hl;
    logic [PROD_W-1:0] r2_p_ll, r2_p_hh;
    logic [XW-1:0]     r2_x_hi;
    logic [CW-1:0]     r2_e_lo, r2_e_hi, r2_z;
    logic [PW-1:0]     r2_pair;
    logic [SLOT_W-1:0] r2_slot;
    logic              r2_col0, r2_last;

    assign w_p_ll = PROD_W'(r1_a_lo) * PROD_W'(r1_s_lo);
    assign w_p_hh = PROD_W'(r1_a_hi) * PROD_W'(r1_s_hi);
    assign w_p_lh = PROD_W'(r1_a_lo) * PROD_W'(r1_s_hi);
    assign w_p_hl = PROD_W'(r1_a_hi) * PROD_W'(r1_s_lo);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p_ll <= w_p_ll;
            r2_p_hh <= w_p_hh;
            r2_x_hi <= XW'(w_p_lh) + XW'(w_p_hl);
            r2_e_lo <= r1_e_lo;
            r2_e_hi <= r1_e_hi;
            r2_z    <= r1_z;
            r2_pair <= r1_pair;
            r2_slot <= r1_slot;
            r2_col0 <= r1_col0;
            r2_last <= r1_last;
        end
    end

    // Stages 3 and 4: reduce a_hi*s_hi and the odd sum.
    logic [CW-1:0] w_r_hh, w_r_hi;

    nbma_mod_reduce #(.X_W(XW)) u_red_hh (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (XW'(r2_p_hh)),
        .o_r   (w_r_hh)
    );

    nbma_mod_reduce #(.X_W(XW)) u_red_hi (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r2_x_hi),
        .o_r   (w_r_hi)
    );

    logic [PROD_W-1:0] r3_p_ll, r4_p_ll;
    logic [CW-1:0]     r3_e_lo, r3_e_hi, r3_z, r4_e_lo, r4_e_hi, r4_z;
    logic [PW-1:0]     r3_pair, r4_pair;
    logic [SLOT_W-1:0] r3_slot, r4_slot;
    logic              r3_col0, r3_last, r4_col0, r4_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_p_ll <= r2_p_ll;
            r3_e_lo <= r2_e_lo;
            r3_e_hi <= r2_e_hi;
            r3_z    <= r2_z;
            r3_pair <= r2_pair;
            r3_slot <= r2_slot;
            r3_col0 <= r2_col0;
            r3_last <= r2_last;
            r4_p_ll <= r3_p_ll;
            r4_e_lo <= r3_e_lo;
            r4_e_hi <= r3_e_hi;
            r4_z    <= r3_z;
            r4_pair <= r3_pair;
            r4_slot <= r3_slot;
            r4_col0 <= r3_col0;
            r4_last <= r3_last;
        end
    end

    // Stage 5: even sum a_lo*s_lo + zeta*(a_hi*s_hi mod q).
    logic [PROD_W-1:0] w_p_z;
    logic [XW-1:0]     r5_x_lo;
    logic [CW-1:0]     r5_r_hi, r5_e_lo, r5_e_hi;
    logic [PW-1:0]     r5_pair;
    logic [SLOT_W-1:0] r5_slot;
    logic              r5_col0, r5_last;

    assign w_p_z = PROD_W'(r4_z) * PROD_W'(w_r_hh);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_x_lo <= XW'(r4_p_ll) + XW'(w_p_z);
            r5_r_hi <= w_r_hi;
            r5_e_lo <= r4_e_lo;
            r5_e_hi <= r4_e_hi;
            r5_pair <= r4_pair;
            r5_slot <= r4_slot;
            r5_col0 <= r4_col0;
            r5_last <= r4_last;
        end
    end

    // Stages 6 and 7: reduce the even sum.
    logic [CW-1:0] w_r_lo;

    nbma_mod_reduce #(.X_W(XW)) u_red_lo (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r5_x_lo),
        .o_r   (w_r_lo)
    );

    logic [CW-1:0]     r6_r_hi, r6_e_lo, r6_e_hi, r7_r_hi, r7_e_lo, r7_e_hi;
    logic [PW-1:0]     r6_pair, r7_pair;
    logic [SLOT_W-1:0] r6_slot, r7_slot;
    logic              r6_col0, r6_last, r7_col0, r7_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_r_hi <= r5_r_hi;
            r6_e_lo <= r5_e_lo;
            r6_e_hi <= r5_e_hi;
            r6_pair <= r5_pair;
            r6_slot <= r5_slot;
            r6_col0 <= r5_col0;
            r6_last <= r5_last;
            r7_r_hi <= r6_r_hi;
            r7_e_lo <= r6_e_lo;
            r7_e_hi <= r6_e_hi;
            r7_pair <= r6_pair;
            r7_slot <= r6_slot;
            r7_col0 <= r6_col0;
            r7_last <= r6_last;
        end
    end

    // Stage 8: accumulate. The sum memory is read as the item enters and
    // written as it leaves; the previous item's update is forwarded.
    logic [2*CW-1:0]   r_mem [PAIRS];
    logic [2*CW-1:0]   r_rd;
    logic [CW-1:0]     r8_r_lo, r8_r_hi, r8_e_lo, r8_e_hi;
    logic [PW-1:0]     r8_pair;
    logic [SLOT_W-1:0] r8_slot;
    logic              r8_col0, r8_last;
    logic [2*CW-1:0]   w_prior;
    logic [2*CW-1:0]   w_acc;

    logic [2*CW-1:0]   r9_acc;
    logic [CW-1:0]     r9_e_lo, r9_e_hi;
    logic [PW-1:0]     r9_pair;
    logic [SLOT_W-1:0] r9_slot;
    logic              r9_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_r_lo <= w_r_lo;
            r8_r_hi <= r7_r_hi;
            r8_e_lo <= r7_e_lo;
            r8_e_hi <= r7_e_hi;
            r8_pair <= r7_pair;
            r8_slot <= r7_slot;
            r8_col0 <= r7_col0;
            r8_last <= r7_last;
        end
    end

    always_comb begin
        w_prior = (r_vld[9] && (r9_slot == r8_slot)) ? r9_acc : r_rd;
        if (r8_col0) begin
            w_acc = {r8_r_hi, r8_r_lo};
        end else begin
            w_acc = {nbma_pkg::add_mod(w_prior[2*CW-1:CW], r8_r_hi),
                     nbma_pkg::add_mod(w_prior[CW-1:0], r8_r_lo)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd <= r_mem[r7_slot];
            if (r_vld[8]) begin
                r_mem[r8_slot] <= w_acc;
            end
        end
    end

    // Stage 9: add the error pair.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_acc  <= w_acc;
            r9_e_lo <= r8_e_lo;
            r9_e_hi <= r8_e_hi;
            r9_pair <= r8_pair;
            r9_slot <= r8_slot;
            r9_last <= r8_last;
        end
    end

    nbma_pkg::t_result w_res;

    always_comb begin
        w_res.lo   = nbma_pkg::add_mod(r9_acc[CW-1:0], r9_e_lo);
        w_res.hi   = nbma_pkg::add_mod(r9_acc[2*CW-1:CW], r9_e_hi);
        w_res.pair = r9_pair;
    end

    // Output buffer.
    nbma_pkg::t_result r_fifo [2];
    logic              r_wptr, r_rptr;
    logic              w_push, w_pop;

    assign w_push = w_en && r_vld[9] && r9_last;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wptr] <= w_res;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {1'b0, r_fifo[r_rptr]};

endmodule

>>> rtl/nbma_mod_reduce.sv
// ----------------------------------------------------------------------------
// nbma_mod_reduce: two-stage Barrett reduction mod q
// Stage one forms the quotient estimate by a reciprocal multiply, stage two
// subtracts the estimate times q and applies one final correction.
// ----------------------------------------------------------------------------
module nbma_mod_reduce #(
    parameter int unsigned X_W = nbma_pkg::RED_X_W
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [X_W-1:0]              i_x,
    output logic [nbma_pkg::COEF_W-1:0] o_r
);

    localparam int unsigned PROD_W = X_W + nbma_pkg::BARRETT_M_W;
    localparam int unsigned QE_W   = PROD_W - nbma_pkg::BARRETT_K;
    localparam int unsigned REM_W  = nbma_pkg::COEF_W + 1;

    logic [PROD_W-1:0]              w_prod;
    logic [QE_W-1:0]                r_qe;
    logic [X_W-1:0]                 r_x;
    logic [X_W-1:0]                 w_rem_full;
    logic [REM_W-1:0]               w_rem;
    logic [REM_W-1:0]               w_fix;
    logic [nbma_pkg::COEF_W-1:0]    r_r;

    assign w_prod = PROD_W'(i_x) * PROD_W'(nbma_pkg::BARRETT_M);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_qe <= w_prod[PROD_W-1:nbma_pkg::BARRETT_K];
        end
    end

    always_comb begin
        w_rem_full = r_x - X_W'(X_W'(r_qe) * X_W'(nbma_pkg::MODQ));
        w_rem      = w_rem_full[REM_W-1:0];
        w_fix      = (w_rem >= REM_W'(nbma_pkg::MODQ)) ? w_rem - REM_W'(nbma_pkg::MODQ)
                                                       : w_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= w_fix[nbma_pkg::COEF_W-1:0];
        end
    end

    assign o_r = r_r;

endmodule
